[rtl/core/gear_ratio_hysteresis_detector_assert.svh]
// Assertion macros used by the core controller module.
`ifndef GEAR_RATIO_HYSTERESIS_DETECTOR_ASSERT_SVH
`define GEAR_RATIO_HYSTERESIS_DETECTOR_ASSERT_SVH

// ante holds -> cons holds in the same cycle
`define GRHD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication check failed");

// ante holds -> cons holds in the cycle after
`define GRHD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// cond must never hold
`define GRHD_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("forbidden condition seen");

`endif

[rtl/core/grhd_pkg.sv]
package grhd_pkg;

    localparam int RATIO_W  = 16;
    localparam int GEAR_W   = 3;
    localparam int CNT_W    = 16;
    localparam int MARGIN_W = 8;
    localparam int STEP_W   = 4;

    localparam int NUM_GEARS  = 5;
    localparam int BAND_COUNT = 5;
    localparam int USED_BANDS = (NUM_GEARS < BAND_COUNT) ? NUM_GEARS : BAND_COUNT;

    localparam logic [GEAR_W-1:0] GEAR_NONE     = 3'd0;
    localparam logic [GEAR_W-1:0] GEAR_NEUTRAL  = 3'd6;
    localparam logic [GEAR_W-1:0] GEAR_CLUTCHED = 3'd7;

    localparam logic [RATIO_W-1:0] RATIO_SAT = '1;
    localparam int TORQUE_ZERO = 128;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    localparam int CFG_ADDR_W = 3;
    localparam logic CFG_UNSTABLE_RELOAD = 1'b0;
    localparam logic CFG_TORQUE_MARGIN   = 1'b1;

    localparam logic [15:0] RELOAD_RST = 16'd2;
    localparam logic [7:0]  MARGIN_RST = 8'd5;

    // band limits, exclusive on both ends
    localparam logic [RATIO_W-1:0] INNER_LO [BAND_COUNT] =
        '{16'd7800, 16'd14800, 16'd21300, 16'd28100, 16'd34700};
    localparam logic [RATIO_W-1:0] INNER_HI [BAND_COUNT] =
        '{16'd8800, 16'd16000, 16'd22500, 16'd29300, 16'd35900};
    localparam logic [RATIO_W-1:0] OUTER_LO [BAND_COUNT] =
        '{16'd7300, 16'd14200, 16'd20700, 16'd27500, 16'd34100};
    localparam logic [RATIO_W-1:0] OUTER_HI [BAND_COUNT] =
        '{16'd9300, 16'd16600, 16'd23100, 16'd29900, 16'd36500};

    typedef struct packed {
        logic load;
        logic div_step;
        logic commit;
    } grhd_cmd_t;

    typedef struct packed {
        logic skip_div;
        logic out_busy;
    } grhd_sts_t;

endpackage

[rtl/core/grhd_ctrl.sv]
module grhd_ctrl
    import grhd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      in_ready,
    input  grhd_sts_t sts,
    output grhd_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_COMMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_cnt_reg, step_cnt_next;

    always_comb begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (s_tvalid) begin
                    cmd.load      = 1'b1;
                    step_cnt_next = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                // ticks and saturated ratios need no division
                if (sts.skip_div) begin
                    state_next = ST_COMMIT;
                end else begin
                    cmd.div_step  = 1'b1;
                    step_cnt_next = step_cnt_reg + 1'b1;
                    if (&step_cnt_reg) begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_COMMIT: begin
                if (!sts.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

`include "gear_ratio_hysteresis_detector_assert.svh"

    `GRHD_ASSERT_NEXT(a_busy_after_load, cmd.load, !in_ready)
    `GRHD_ASSERT_NEVER(a_no_result_overwrite, cmd.commit && sts.out_busy)
    `GRHD_ASSERT_NEXT(a_last_step_commits, cmd.div_step && (&step_cnt_reg),
        state_reg == ST_COMMIT)

endmodule

[rtl/core/grhd_dp.sv]
module grhd_dp
    import grhd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  grhd_cmd_t           cmd,
    output grhd_sts_t           sts,
    input  logic                in_tick,
    input  logic [15:0]         in_speed,
    input  logic [15:0]         in_rpm,
    input  logic [15:0]         in_torque,
    input  logic                in_moving,
    input  logic                in_stopped,
    input  logic                in_clutch,
    input  logic [CNT_W-1:0]    unstable_reload,
    input  logic [MARGIN_W-1:0] torque_margin,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [RATIO_W-1:0]  out_ratio,
    output logic [GEAR_W-1:0]   out_detected,
    output logic [GEAR_W-1:0]   out_reported
);

    // captured item
    logic                tick_reg;
    logic [15:0]         rpm_reg;
    logic [15:0]         torque_reg;
    logic                moving_reg, stopped_reg, clutch_reg;
    logic                sat_reg;

    // divider
    logic [15:0]         rem_reg, rem_next;
    logic [RATIO_W-1:0]  quo_reg, quo_next;
    logic [16:0]         rem_sh;
    logic                rem_ge;

    // detector state
    logic [RATIO_W-1:0]  ratio_reg, ratio_next;
    logic [GEAR_W-1:0]   gear_reg, gear_next;
    logic [GEAR_W-1:0]   shown_reg, shown_next;
    logic [CNT_W-1:0]    unst_cnt_reg, unst_cnt_next;
    logic [CNT_W-1:0]    torq_cnt_reg, torq_cnt_next;
    logic                out_valid_reg;

    logic [RATIO_W-1:0]  new_ratio;
    logic [GEAR_W-1:0]   new_gear;
    logic                held;
    logic signed [17:0]  tq_s, tq_lo, tq_hi;
    logic                torque_low;

    // restoring division step; remainder always stays below rpm
    always_comb begin
        rem_sh   = {rem_reg, 1'b0};
        rem_ge   = rem_sh >= {1'b0, rpm_reg};
        rem_next = rem_ge ? 16'(rem_sh - {1'b0, rpm_reg}) : rem_sh[15:0];
        quo_next = {quo_reg[RATIO_W-2:0], rem_ge};
    end

    always_comb begin
        new_ratio = sat_reg ? RATIO_SAT : quo_reg;

        held = 1'b0;
        for (int i = 0; i < USED_BANDS; i++) begin
            if (gear_reg == GEAR_W'(i + 1) && new_ratio > OUTER_LO[i] &&
                new_ratio < OUTER_HI[i]) begin
                held = 1'b1;
            end
        end
        new_gear = GEAR_NONE;
        for (int i = USED_BANDS - 1; i >= 0; i--) begin
            if (new_ratio > INNER_LO[i] && new_ratio < INNER_HI[i]) begin
                new_gear = GEAR_W'(i + 1);
            end
        end
        if (held) begin
            new_gear = gear_reg;
        end

        tq_s       = $signed({2'b00, torque_reg});
        tq_lo      = 18'sd128 - $signed({10'd0, torque_margin});
        tq_hi      = 18'sd128 + $signed({10'd0, torque_margin});
        torque_low = (tq_s < tq_hi) && (tq_s > tq_lo);
    end

    always_comb begin
        ratio_next    = ratio_reg;
        gear_next     = gear_reg;
        shown_next    = shown_reg;
        unst_cnt_next = unst_cnt_reg;
        torq_cnt_next = torq_cnt_reg;
        if (cmd.commit) begin
            if (tick_reg) begin
                if (unst_cnt_reg != '0) unst_cnt_next = unst_cnt_reg - 1'b1;
                if (torq_cnt_reg != '0) torq_cnt_next = torq_cnt_reg - 1'b1;
            end else begin
                ratio_next = new_ratio;
                gear_next  = new_gear;
                if (new_gear != gear_reg) unst_cnt_next = unstable_reload;
                if (torque_low)           torq_cnt_next = unstable_reload;
                if (!moving_reg || stopped_reg) begin
                    shown_next = GEAR_NEUTRAL;
                end else if (clutch_reg) begin
                    shown_next = GEAR_CLUTCHED;
                end else if (unst_cnt_next == '0 && torq_cnt_next == '0) begin
                    shown_next = new_gear;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            tick_reg    <= (in_tick == REQ_TICK);
            rpm_reg     <= in_rpm;
            torque_reg  <= in_torque;
            moving_reg  <= in_moving;
            stopped_reg <= in_stopped;
            clutch_reg  <= in_clutch;
            // quotient overflows exactly when speed >= rpm
            sat_reg     <= (in_rpm == '0) || (in_speed >= in_rpm);
            rem_reg     <= in_speed;
            quo_reg     <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg     <= '0;
            gear_reg      <= GEAR_NONE;
            shown_reg     <= GEAR_NEUTRAL;
            unst_cnt_reg  <= '0;
            torq_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            ratio_reg    <= ratio_next;
            gear_reg     <= gear_next;
            shown_reg    <= shown_next;
            unst_cnt_reg <= unst_cnt_next;
            torq_cnt_reg <= torq_cnt_next;
            if (cmd.commit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.skip_div = tick_reg || sat_reg;
    assign sts.out_busy = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign out_ratio    = ratio_reg;
    assign out_detected = gear_reg;
    assign out_reported = shown_reg;

endmodule

[rtl/core/gear_ratio_hysteresis_detector.sv]
// Channel   | Dir | Handshake         | Payload
// s_ (item) | in  | s_tvalid/s_tready | s_tdata sensor sample, s_tuser request kind
// m_ (item) | out | m_tvalid/m_tready | m_tdata ratio and gears
// apb       | in  | psel/penable      | two config registers at 0x0 and 0x4
//
// Update item: accept, 16 steps of the radix-2 ratio divider, then commit; a saturated
// ratio skips the divider steps. Tick item: accept, then commit with no divider steps.
// A new item is taken while the previous result still waits in the output register.
// A stalled m_ side holds the commit, and with it the next item's result.
// Synchronous active-low reset; detector state clears to ratio 0, gear 0, neutral.
module gear_ratio_hysteresis_detector
    import grhd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] vehicle_speed, [31:16] engine_speed, [47:32] engine_torque,
    // [48] vehicle_moving, [49] engine_stopped, [50] clutch_down, [55:51] zero
    input  logic [55:0]           s_tdata,
    // [0] req_type
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] ratio, [18:16] detected_gear, [21:19] reported_gear, [23:22] zero
    output logic [23:0]           m_tdata,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    grhd_cmd_t cmd;
    grhd_sts_t sts;

    logic [CNT_W-1:0]    reload_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [RATIO_W-1:0]  out_ratio;
    logic [GEAR_W-1:0]   out_detected, out_reported;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg <= RELOAD_RST;
            margin_reg <= MARGIN_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                CFG_UNSTABLE_RELOAD: reload_reg <= pwdata[CNT_W-1:0];
                CFG_TORQUE_MARGIN:   margin_reg <= pwdata[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            CFG_UNSTABLE_RELOAD: prdata = {16'd0, reload_reg};
            CFG_TORQUE_MARGIN:   prdata = {24'd0, margin_reg};
            default:             prdata = '0;
        endcase
    end

    grhd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    grhd_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .in_tick         (s_tuser),
        .in_speed        (s_tdata[15:0]),
        .in_rpm          (s_tdata[31:16]),
        .in_torque       (s_tdata[47:32]),
        .in_moving       (s_tdata[48]),
        .in_stopped      (s_tdata[49]),
        .in_clutch       (s_tdata[50]),
        .unstable_reload (reload_reg),
        .torque_margin   (margin_reg),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_ratio       (out_ratio),
        .out_detected    (out_detected),
        .out_reported    (out_reported)
    );

    assign m_tdata = {2'b00, out_reported, out_detected, out_ratio};

endmodule
